// ----- src/qrae_pkg.sv -----
package qrae_pkg;

	localparam int unsigned SetSize    = 45;
	localparam int unsigned PairBits   = 11;
	localparam int unsigned SingleBits = 6;
	localparam int unsigned QDepth     = 4;
	localparam int unsigned QIdxW      = $clog2(QDepth);
	localparam int unsigned QCntW      = $clog2(QDepth + 1);
	localparam int unsigned MaxRes     = 3;

	localparam logic [2:0] RegStartBitOffset = 3'd0;

	typedef struct packed {
		logic [5:0] idx;
		logic       bad;
	} lookup_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [3:0] bits_valid;
		logic       last_out;
		logic       bad_char;
	} res_t;

	function automatic lookup_t char_lookup(input logic [7:0] c);
		lookup_t r;
		r.bad = 1'b0;
		r.idx = 6'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.idx = 6'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			r.idx = 6'(c - 8'h37);
		end else begin
			unique case (c)
				8'h20:   r.idx = 6'd36;
				8'h24:   r.idx = 6'd37;
				8'h25:   r.idx = 6'd38;
				8'h2A:   r.idx = 6'd39;
				8'h2B:   r.idx = 6'd40;
				8'h2D:   r.idx = 6'd41;
				8'h2E:   r.idx = 6'd42;
				8'h2F:   r.idx = 6'd43;
				8'h3A:   r.idx = 6'd44;
				default: r.bad = 1'b1;
			endcase
		end
		return r;
	endfunction

endpackage

// ----- src/qr_alphanumeric_encoder.sv -----
// Flow: a character word is registered into the encode stage when it is taken, and the
// encode stage writes its output words into the output queue when it advances.
// Throughput: one character per cycle while the four-entry output queue holds at most one
// word; the queue drains one word per cycle with the receiver ready, and a pair that yields
// two words, or a final pair that yields three, holds off the input until it holds one or none.
// Reset (arst_n low, asynchronous): queue and encode stage empty, no open pair, no partial
// bits, next character starts a new text, start_bit_offset cleared to zero.
module qr_alphanumeric_encoder
	import qrae_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // last_char
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] bits_valid, [15:12] zero
	output logic        m_tlast,   // last_out
	output logic        m_tuser    // bad_char
);

	logic [2:0] offset_q;

	logic       s1_valid_q;
	logic [7:0] char_s1;
	logic       last_s1;

	logic [5:0] held_idx_q;
	logic       held_valid_q;
	logic       held_bad_q;
	logic [6:0] pbits_q;
	logic [2:0] pcount_q;
	logic       pbad_q;
	logic       first_q;

	res_t             q_q [QDepth];
	res_t             q_d [QDepth];
	logic [QCntW-1:0] cnt_q;
	logic [QCntW-1:0] cnt_d;

	// config
	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegStartBitOffset[0]) ? {29'd0, offset_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 3'd0;
		end else if (psel && penable && pwrite && paddr[2] == RegStartBitOffset[0]) begin
			offset_q <= pwdata[2:0];
		end
	end

	// encode stage
	logic    s1_go;
	logic    pop;
	lookup_t lk;
	logic    hold;
	logic [2:0]  pc;
	logic [6:0]  pb;
	logic        pbad;
	logic [10:0] code;
	logic [3:0]  len;
	logic        code_bad;
	logic [17:0] acc;
	logic [4:0]  n;
	logic [1:0]  full;
	logic [2:0]  rem;
	logic [25:0] fl_wide;
	logic [7:0]  byte0;
	logic [7:0]  byte1;
	logic [7:0]  flush;
	logic        has_flush;
	logic [1:0]  nres;
	res_t        res [MaxRes];

	assign pop      = m_tvalid && m_tready;
	assign s1_go    = s1_valid_q && (cnt_q <= QCntW'(1));
	assign s_tready = !s1_valid_q || s1_go;

	always_comb begin
		lk   = char_lookup(char_s1);
		pc   = first_q ? offset_q : pcount_q;
		pb   = first_q ? 7'd0 : pbits_q;
		pbad = first_q ? 1'b0 : pbad_q;
		hold = !held_valid_q && !last_s1;
		if (held_valid_q) begin
			code     = 11'({5'd0, held_idx_q} * 11'(SetSize)) + {5'd0, lk.idx};
			len      = 4'(PairBits);
			code_bad = held_bad_q || lk.bad;
		end else begin
			code     = {5'd0, lk.idx};
			len      = 4'(SingleBits);
			code_bad = lk.bad;
		end
		acc     = (18'(pb) << len) | 18'(code);
		n       = {2'd0, pc} + {1'b0, len};
		full    = (n >= 5'd16) ? 2'd2 : ((n >= 5'd8) ? 2'd1 : 2'd0);
		rem     = n[2:0];
		byte0   = 8'(acc >> (n - 5'd8));
		byte1   = 8'(acc >> (n - 5'd16));
		fl_wide = 26'(acc) << (4'd8 - {1'b0, rem});
		flush   = fl_wide[7:0];
		has_flush = last_s1 && (rem != 3'd0);
		nres    = hold ? 2'd0 : full + {1'b0, has_flush};

		res[2] = '{out_byte: flush, bits_valid: {1'b0, rem}, last_out: 1'b1,
			bad_char: code_bad};
		// first full word also carries the bits left over from the previous code
		res[0] = (full != 2'd0)
			? '{out_byte: byte0, bits_valid: 4'd8,
				last_out: last_s1 && rem == 3'd0 && full == 2'd1,
				bad_char: code_bad || (pc != 3'd0 && pbad)}
			: res[2];
		res[1] = (full == 2'd2)
			? '{out_byte: byte1, bits_valid: 4'd8,
				last_out: last_s1 && rem == 3'd0, bad_char: code_bad}
			: res[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_idx_q   <= 6'd0;
			held_valid_q <= 1'b0;
			held_bad_q   <= 1'b0;
			pbits_q      <= 7'd0;
			pcount_q     <= 3'd0;
			pbad_q       <= 1'b0;
			first_q      <= 1'b1;
		end else if (s1_go) begin
			if (hold) begin
				held_idx_q   <= lk.idx;
				held_valid_q <= 1'b1;
				held_bad_q   <= lk.bad;
				pbits_q      <= pb;
				pcount_q     <= pc;
				pbad_q       <= pbad;
				first_q      <= 1'b0;
			end else begin
				held_idx_q   <= 6'd0;
				held_valid_q <= 1'b0;
				held_bad_q   <= 1'b0;
				if (last_s1) begin
					pbits_q  <= 7'd0;
					pcount_q <= 3'd0;
					pbad_q   <= 1'b0;
					first_q  <= 1'b1;
				end else begin
					pbits_q  <= 7'(acc) & (7'h7F >> (3'd7 - rem));
					pcount_q <= rem;
					pbad_q   <= (rem != 3'd0) && code_bad;
					first_q  <= 1'b0;
				end
			end
		end
	end

	// output queue: head at entry 0, shifts down on each taken word
	always_comb begin
		logic [QCntW-1:0] base;
		for (int i = 0; i < QDepth; i++) begin
			q_d[i] = q_q[i];
		end
		base = cnt_q;
		if (pop) begin
			for (int i = 0; i < QDepth - 1; i++) begin
				q_d[i] = q_q[i + 1];
			end
			base = cnt_q - QCntW'(1);
		end
		cnt_d = base;
		if (s1_go) begin
			for (int j = 0; j < MaxRes; j++) begin
				if (2'(j) < nres) begin
					q_d[QIdxW'(base + QCntW'(j))] = res[j];
				end
			end
			cnt_d = base + QCntW'(nres);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDepth; i++) begin
			q_q[i] <= q_d[i];
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {4'd0, q_q[0].bits_valid, q_q[0].out_byte};
	assign m_tlast  = q_q[0].last_out;
	assign m_tuser  = q_q[0].bad_char;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QDepth))
		else $error("output queue overfilled");

	a_mid_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> q_q[0].bits_valid == 4'd8)
		else $error("partial word before end of text");

	a_pair_open: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && hold |=> held_valid_q && !first_q)
		else $error("pair not opened");

	a_text_end: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && last_s1 |=> first_q && !held_valid_q && pcount_q == 3'd0)
		else $error("stream state not cleared at end of text");

endmodule
